// ----- src/clm_pkg.sv -----
// ----------------------------------------------------------------------------
// Receive current limit monitor: shared definitions
// Field widths, command and register index codes, and fixed limits used by
// the channel interfaces and the monitor core.
// ----------------------------------------------------------------------------
package clm_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int TEMP_W     = 8;
    localparam int SEC_W      = 32;
    localparam int MA_W       = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 56;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IC_LIMIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_BAND_0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_BAND_1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_BAND_2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_ROWS_01   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_ROWS_23   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_ROWS_45   = 3'd7;

    // Register set geometry
    localparam int BAND_REGS = 3;
    localparam int ROW_REGS  = 6;
    localparam int BAND_BITS = 36;
    localparam int ROW_BITS  = 28;

    // Fixed behavior
    localparam int              SAMPLE_COUNT_DEF   = 10;
    localparam int              TEMP_BANDS_DEF     = 3;
    localparam int              TIME_ROWS          = 6;
    localparam logic [MA_W-1:0] DEFAULT_LIMIT      = 12'd1300;
    localparam logic [MA_W-1:0] DEFAULT_IC_LIMIT   = 12'd1300;
    localparam logic [MA_W-1:0] PRESET_SAMPLE      = 12'd100;
    localparam logic [SEC_W-1:0] START_HOLD_SECONDS = 32'd10;

endpackage

// ----- src/clm_ifs.sv -----
// ----------------------------------------------------------------------------
// Receive current limit monitor: channel interfaces
// Tick request, result and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------

// Tick request channel
interface clm_req_if;
    logic                                valid;
    logic                                ready;
    logic        [clm_pkg::CMD_W-1:0]    command;
    logic signed [clm_pkg::TEMP_W-1:0]   temperature;
    logic        [clm_pkg::SEC_W-1:0]    now_seconds;
    logic        [clm_pkg::MA_W-1:0]     current_sample;
    logic                                time_table_active;

    modport source (
        output valid, command, temperature, now_seconds, current_sample,
               time_table_active,
        input  ready
    );
    modport sink (
        input  valid, command, temperature, now_seconds, current_sample,
               time_table_active,
        output ready
    );
endinterface

// Result channel
interface clm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [clm_pkg::MA_W-1:0]    current_limit;
    logic [clm_pkg::MA_W-1:0]    average_current;

    modport source (output valid, current_limit, average_current, input ready);
    modport sink   (input  valid, current_limit, average_current, output ready);
endinterface

// Register write channel
interface clm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [clm_pkg::CFG_IDX_W-1:0]     index;
    logic [clm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

// ----- src/rx_current_limit_monitor_core.sv -----
// ----------------------------------------------------------------------------
// Receive current limit monitor core
// Per tick: temperature band limit with hysteresis, elapsed time row limit,
// IC limit, minimum of the three, and a boxcar mean of the current samples.
//
//   port  | role   | transaction
//   ------+--------+-------------------------------------------------------
//   req   | sink   | command, temperature, now_seconds, current_sample,
//         |        | time_table_active
//   rsp   | source | current_limit, average_current (one per request)
//   cfg   | sink   | register write: index, data (always ready)
//
// One request per cycle while req.ready is high; its result passes the limit
// search, then sample memory read-modify-write and running sum, then
// reciprocal multiply for the mean on the way into the output queue.
// The sample ring is a one-port-read, one-port-write memory with a registered
// read; per-entry valid bits give the reset and stop presets.
// rst_n is asynchronous; no clearing pass follows reset.
// req.ready drops when the 4-entry result queue plus in-flight requests are
// full, so rsp stalls never lose a result.
// ----------------------------------------------------------------------------
module rx_current_limit_monitor_core #(
    parameter int SAMPLE_COUNT = clm_pkg::SAMPLE_COUNT_DEF,
    parameter int TEMP_BANDS   = clm_pkg::TEMP_BANDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    clm_cfg_if.sink       cfg,
    clm_req_if.sink       req,
    clm_rsp_if.source     rsp
);
    import clm_pkg::*;

    localparam int IDX_W      = $clog2(SAMPLE_COUNT);
    localparam int SUM_W      = MA_W + IDX_W;
    localparam int DIV_SHIFT  = SUM_W + IDX_W;
    localparam int RECIP_W    = SUM_W + 1;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_FULL);
    localparam logic [SUM_W-1:0]   PRESET_SUM = SUM_W'(int'(PRESET_SAMPLE) * SAMPLE_COUNT);
    localparam int BAND_W     = (TEMP_BANDS > 1) ? $clog2(TEMP_BANDS) : 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;

    typedef struct packed {
        logic        [MA_W-1:0]   limit;
        logic        [TEMP_W-1:0] back;
        logic signed [TEMP_W-1:0] high;
        logic signed [TEMP_W-1:0] low;
    } band_t;

    typedef struct packed {
        logic [MA_W-1:0] limit;
        logic [15:0]     thresh;
    } row_t;

    typedef struct packed {
        logic [MA_W-1:0] current_limit;
        logic [MA_W-1:0] average_current;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SAMPLE,
        OP_PRESET
    } op_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic            mon_en_reg;
    logic [MA_W-1:0] ic_limit_reg;
    band_t           band_reg [BAND_REGS];
    row_t            row_reg  [ROW_REGS];

    assign cfg.ready = 1'b1;

    // Capture register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mon_en_reg   <= 1'b0;
            ic_limit_reg <= '0;
            for (int i = 0; i < BAND_REGS; i++)
            begin
                band_reg[i] <= '0;
            end
            for (int i = 0; i < ROW_REGS; i++)
            begin
                row_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MONITOR_ENABLE: mon_en_reg   <= cfg.data[0];
                CFG_IC_LIMIT:       ic_limit_reg <= cfg.data[MA_W-1:0];
                CFG_TEMP_BAND_0:    band_reg[0]  <= band_t'(cfg.data[BAND_BITS-1:0]);
                CFG_TEMP_BAND_1:    band_reg[1]  <= band_t'(cfg.data[BAND_BITS-1:0]);
                CFG_TEMP_BAND_2:    band_reg[2]  <= band_t'(cfg.data[BAND_BITS-1:0]);
                CFG_TIME_ROWS_01:
                begin
                    row_reg[0] <= row_t'(cfg.data[ROW_BITS-1:0]);
                    row_reg[1] <= row_t'(cfg.data[2*ROW_BITS-1:ROW_BITS]);
                end
                CFG_TIME_ROWS_23:
                begin
                    row_reg[2] <= row_t'(cfg.data[ROW_BITS-1:0]);
                    row_reg[3] <= row_t'(cfg.data[2*ROW_BITS-1:ROW_BITS]);
                end
                CFG_TIME_ROWS_45:
                begin
                    row_reg[4] <= row_t'(cfg.data[ROW_BITS-1:0]);
                    row_reg[5] <= row_t'(cfg.data[2*ROW_BITS-1:ROW_BITS]);
                end
            endcase
        end
    end

    // Bands and rows beyond the register set read as zero entries
    band_t band_ent [TEMP_BANDS];
    row_t  row_ent  [TIME_ROWS];

    for (genvar g = 0; g < TEMP_BANDS; g++)
    begin : g_band
        if (g < BAND_REGS)
        begin : g_reg
            assign band_ent[g] = band_reg[g];
        end
        else
        begin : g_zero
            assign band_ent[g] = '0;
        end
    end

    for (genvar g = 0; g < TIME_ROWS; g++)
    begin : g_row
        if (g < ROW_REGS)
        begin : g_reg
            assign row_ent[g] = row_reg[g];
        end
        else
        begin : g_zero
            assign row_ent[g] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: accept, decode, limit search, control state update
    // ------------------------------------------------------------------
    logic              req_fire;
    logic              is_tick;
    logic              is_start;
    logic              is_stop;
    logic              do_sample;
    logic              do_limit;
    logic              do_preset;

    logic [SEC_W-1:0]  origin_sec_reg;
    logic [BAND_W-1:0] last_band_reg;
    logic              first_tick_reg;
    logic              stopped_reg;
    logic [IDX_W-1:0]  ring_ptr_reg;

    assign req_fire  = req.valid && req.ready;
    assign is_tick   = (req.command == CMD_TICK);
    assign is_start  = (req.command == CMD_START);
    assign is_stop   = (req.command == CMD_STOP);
    assign do_sample = is_tick && !stopped_reg;
    assign do_limit  = do_sample && mon_en_reg;
    assign do_preset = is_stop || (is_tick && stopped_reg);

    // Temperature band search: first band with low < temp <= high
    logic              band_found;
    logic [BAND_W-1:0] band_hit;
    logic              band_take;
    logic [BAND_W-1:0] band_sel;
    logic [MA_W-1:0]   band_lim;
    logic              band_ok;
    logic [MA_W-1:0]   temp_lim;

    always_comb
    begin
        logic [TEMP_W:0] margin;
        logic            match;
        band_found = 1'b0;
        band_hit   = '0;
        band_take  = 1'b0;
        for (int i = TEMP_BANDS - 1; i >= 0; i--)
        begin
            match  = ($signed(req.temperature) > $signed(band_ent[i].low)) &&
                     ($signed(req.temperature) <= $signed(band_ent[i].high));
            margin = {band_ent[i].high[TEMP_W-1], band_ent[i].high} -
                     {req.temperature[TEMP_W-1], req.temperature};
            if (match)
            begin
                band_found = 1'b1;
                band_hit   = BAND_W'(i);
                band_take  = first_tick_reg || (last_band_reg < BAND_W'(i)) ||
                             (margin > {1'b0, band_ent[i].back});
            end
        end
    end

    assign band_sel = band_take ? band_hit : last_band_reg;
    assign band_lim = band_ent[band_sel].limit;
    assign band_ok  = band_found && (band_lim != '0);
    assign temp_lim = band_ok ? band_lim : DEFAULT_LIMIT;

    // Time row search: first row whose threshold the elapsed time reaches
    logic              start_load;
    logic [SEC_W-1:0]  start_new;
    logic [SEC_W-1:0]  elapsed;
    logic              row_found;
    logic [MA_W-1:0]   row_lim;
    logic [MA_W-1:0]   time_lim;
    logic [MA_W-1:0]   ic_eff;

    assign start_load = first_tick_reg || (origin_sec_reg < START_HOLD_SECONDS);
    assign start_new  = start_load ? req.now_seconds : origin_sec_reg;
    assign elapsed    = req.now_seconds - start_new;

    always_comb
    begin
        row_found = 1'b0;
        row_lim   = '0;
        for (int i = TIME_ROWS - 1; i >= 0; i--)
        begin
            if (elapsed >= SEC_W'(row_ent[i].thresh))
            begin
                row_found = 1'b1;
                row_lim   = row_ent[i].limit;
            end
        end
    end

    assign time_lim = (req.time_table_active && row_found && (row_lim != '0)) ?
                      row_lim : DEFAULT_LIMIT;
    assign ic_eff   = (ic_limit_reg != '0) ? ic_limit_reg : DEFAULT_IC_LIMIT;

    // Update monitor control state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_sec_reg <= '0;
            last_band_reg  <= '0;
            first_tick_reg <= 1'b0;
            stopped_reg    <= 1'b0;
            ring_ptr_reg   <= '0;
        end
        else if (req_fire)
        begin
            if (is_start)
            begin
                stopped_reg <= 1'b0;
                if (mon_en_reg)
                begin
                    first_tick_reg <= 1'b1;
                end
            end
            else if (is_stop)
            begin
                stopped_reg <= 1'b1;
            end
            else if (do_limit)
            begin
                first_tick_reg <= 1'b0;
                origin_sec_reg <= start_new;
                if (band_ok)
                begin
                    last_band_reg <= band_sel;
                end
            end
            if (do_sample)
            begin
                ring_ptr_reg <= (ring_ptr_reg == IDX_W'(SAMPLE_COUNT - 1)) ?
                                '0 : ring_ptr_reg + 1'b1;
            end
        end
    end

    // Stage A to B pipeline register
    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic             s1_upd_reg;
    logic [MA_W-1:0]  s1_ic_reg;
    logic [MA_W-1:0]  s1_lt_reg;
    logic [MA_W-1:0]  s1_lm_reg;
    logic [MA_W-1:0]  s1_sample_reg;
    logic [IDX_W-1:0] s1_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= OP_NONE;
            s1_upd_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req_fire;
            s1_upd_reg   <= req_fire && do_limit;
            if (do_sample)
            begin
                s1_op_reg <= OP_SAMPLE;
            end
            else if (do_preset)
            begin
                s1_op_reg <= OP_PRESET;
            end
            else
            begin
                s1_op_reg <= OP_NONE;
            end
        end
    end

    // Payload of stage A, no reset
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_ic_reg     <= ic_eff;
            s1_lt_reg     <= temp_lim;
            s1_lm_reg     <= time_lim;
            s1_sample_reg <= req.current_sample;
            s1_addr_reg   <= ring_ptr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sample ring memory: read in stage A, written back in stage B
    // ------------------------------------------------------------------
    logic [MA_W-1:0]         ring_mem [SAMPLE_COUNT];
    logic [MA_W-1:0]         ring_rd_reg;
    logic [SAMPLE_COUNT-1:0] ring_vld_reg;
    logic                    fill_hi_reg;

    // Read the entry the sample will replace
    always_ff @(posedge clk)
    begin
        if (req_fire && do_sample)
        begin
            ring_rd_reg <= ring_mem[ring_ptr_reg];
        end
    end

    // Write the new sample back
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && (s1_op_reg == OP_SAMPLE))
        begin
            ring_mem[s1_addr_reg] <= s1_sample_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: running sum and limit minimum
    // ------------------------------------------------------------------
    logic [MA_W-1:0]  old_sample;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [MA_W-1:0]  lim_ic_temp;
    logic [MA_W-1:0]  limit_next;
    logic [MA_W-1:0]  limit_now_reg;
    logic             s2_valid_reg;

    assign old_sample  = ring_vld_reg[s1_addr_reg] ? ring_rd_reg :
                         (fill_hi_reg ? PRESET_SAMPLE : '0);
    assign sum_next    = sum_reg - SUM_W'(old_sample) + SUM_W'(s1_sample_reg);
    assign lim_ic_temp = (s1_lt_reg < s1_ic_reg) ? s1_lt_reg : s1_ic_reg;
    assign limit_next  = (s1_lm_reg < lim_ic_temp) ? s1_lm_reg : lim_ic_temp;

    // Advance sum, entry valid bits and the held limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            ring_vld_reg  <= '0;
            fill_hi_reg   <= 1'b0;
            limit_now_reg <= DEFAULT_LIMIT;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                unique case (s1_op_reg)
                    OP_SAMPLE:
                    begin
                        sum_reg                   <= sum_next;
                        ring_vld_reg[s1_addr_reg] <= 1'b1;
                    end
                    OP_PRESET:
                    begin
                        sum_reg      <= PRESET_SUM;
                        ring_vld_reg <= '0;
                        fill_hi_reg  <= 1'b1;
                    end
                    default:
                    begin
                        sum_reg <= sum_reg;
                    end
                endcase
                if (s1_upd_reg)
                begin
                    limit_now_reg <= limit_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: mean by reciprocal multiply, push into result queue
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] mean_prod;
    logic [MA_W-1:0]   mean;

    assign mean_prod = {{RECIP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RECIP};
    assign mean      = mean_prod[DIV_SHIFT +: MA_W];

    rsp_t              fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;
    logic [CNT_W-1:0]   occupancy;

    assign push      = s2_valid_reg;
    assign pop       = rsp.valid && rsp.ready;
    assign occupancy = count_reg + CNT_W'(s1_valid_reg) + CNT_W'(s2_valid_reg);
    assign req.ready = (occupancy < CNT_W'(FIFO_DEPTH));

    // Hold queue entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{current_limit: limit_now_reg, average_current: mean};
        end
    end

    // Advance queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    assign rsp.valid           = (count_reg != '0);
    assign rsp.current_limit   = fifo_mem[rd_ptr_reg].current_limit;
    assign rsp.average_current = fifo_mem[rd_ptr_reg].average_current;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_credit: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= CNT_W'(FIFO_DEPTH))
        else $error("result queue credit overrun");

    a_preset_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_op_reg == OP_PRESET)) |=> (sum_reg == PRESET_SUM))
        else $error("running sum not preset after stop");

    a_ring_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, ring_ptr_reg} < (IDX_W + 1)'(SAMPLE_COUNT))
        else $error("ring pointer out of range");

    a_limit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        limit_now_reg != '0)
        else $error("current limit dropped to zero");

    a_first_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && do_limit) |=> !first_tick_reg)
        else $error("first tick flag not cleared after limit update");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Receive current limit monitor core: self-checking testbench
// Drives ticks, start and stop commands and register writes into the core.
// A cycle-free predictor of the band, time-row and IC limits and of the
// ten-sample mean runs on every accepted request. Each result is compared
// with the oldest prediction. Directed cases come first, then random phases
// with fresh register settings and random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import clm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam int               DRAIN_SLACK  = 8;
    localparam int               WATCHDOG_MAX = 2000;
    localparam int               PRINT_MAX    = 30;

    typedef struct packed {
        logic [MA_W-1:0] limit;
        logic [MA_W-1:0] mean;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n;

    clm_req_if req();
    clm_rsp_if rsp();
    clm_cfg_if cfg();

    rx_current_limit_monitor_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    // Predictor copy of the registers
    logic                  mon_enable;
    logic [MA_W-1:0]       ic_cfg;
    logic [BAND_BITS-1:0]  band_cfg [BAND_REGS];
    logic [ROW_BITS-1:0]   row_cfg  [ROW_REGS];

    // Predictor copy of the monitor state
    logic [SEC_W-1:0]      origin_sec;
    logic [1:0]            last_band;
    logic                  first_tick;
    logic                  stopped;
    logic [MA_W-1:0]       limit_now;
    logic [MA_W-1:0]       sample_ring [SAMPLE_COUNT_DEF];
    int                    ring_pos;
    logic [MA_W-1:0]       mean_now;

    // Register values staged for the next settings load
    logic [BAND_BITS-1:0]  band_words [BAND_REGS];
    logic [ROW_BITS-1:0]   row_words  [ROW_REGS];

    reading_t expected_readings [$];

    bit idling_on;
    int stall_left;
    int quiet_cycles;
    int mismatches;
    int items_sent;
    int results_seen;
    int writes_done;

    // Clock
    always #5 clk = ~clk;

    function automatic logic [BAND_BITS-1:0] pack_band(input int lo, input int hi,
                                                       input int back, input int lim);
        return {12'(lim), 8'(back), 8'(hi), 8'(lo)};
    endfunction

    function automatic logic [ROW_BITS-1:0] pack_row(input int threshold, input int lim);
        return {12'(lim), 16'(threshold)};
    endfunction

    // Advance the predicted monitor by one accepted request and queue its result
    task automatic advance_monitor(input logic [CMD_W-1:0] cmd,
                                   input logic signed [TEMP_W-1:0] temp,
                                   input logic [SEC_W-1:0] now,
                                   input logic [MA_W-1:0] sample_ma,
                                   input logic active);
        int              t, lo, hi, margin;
        int unsigned     sum;
        logic [MA_W-1:0] lim, band_lim, row_lim, field;
        logic [1:0]      pick;
        logic [SEC_W-1:0] elapsed;
        bit              hit;
        reading_t        r;
        t = temp;
        case (cmd)
            CMD_START:
            begin
                stopped = 1'b0;
                if (mon_enable)
                    first_tick = 1'b1;
            end
            CMD_STOP:
            begin
                stopped = 1'b1;
                foreach (sample_ring[i])
                    sample_ring[i] = PRESET_SAMPLE;
                mean_now = PRESET_SAMPLE;
            end
            CMD_TICK:
            begin
                if (stopped)
                begin
                    foreach (sample_ring[i])
                        sample_ring[i] = PRESET_SAMPLE;
                    mean_now = PRESET_SAMPLE;
                end
                else
                begin
                    if (mon_enable)
                    begin
                        lim = (ic_cfg != '0) ? ic_cfg : DEFAULT_IC_LIMIT;
                        // Band search with hysteresis toward lower bands
                        band_lim = DEFAULT_LIMIT;
                        hit = 1'b0;
                        pick = last_band;
                        for (int i = 0; i < BAND_REGS; i++)
                        begin
                            lo = signed'(band_cfg[i][7:0]);
                            hi = signed'(band_cfg[i][15:8]);
                            margin = band_cfg[i][23:16];
                            if (!hit && t > lo && t <= hi)
                            begin
                                hit = 1'b1;
                                if (first_tick || last_band < i || hi - t > margin)
                                    pick = 2'(i);
                            end
                        end
                        if (hit)
                        begin
                            field = band_cfg[pick][35:24];
                            if (field != '0)
                            begin
                                band_lim = field;
                                last_band = pick;
                            end
                        end
                        // Time row search on seconds since start
                        if (first_tick || origin_sec < START_HOLD_SECONDS)
                            origin_sec = now;
                        row_lim = DEFAULT_LIMIT;
                        if (active)
                        begin
                            elapsed = now - origin_sec;
                            hit = 1'b0;
                            for (int i = 0; i < ROW_REGS; i++)
                            begin
                                if (!hit && elapsed >= row_cfg[i][15:0])
                                begin
                                    hit = 1'b1;
                                    field = row_cfg[i][27:16];
                                    if (field != '0)
                                        row_lim = field;
                                end
                            end
                        end
                        if (band_lim < lim)
                            lim = band_lim;
                        if (row_lim < lim)
                            lim = row_lim;
                        limit_now = lim;
                        first_tick = 1'b0;
                    end
                    // Boxcar mean
                    sample_ring[ring_pos] = sample_ma;
                    ring_pos = (ring_pos == SAMPLE_COUNT_DEF - 1) ? 0 : ring_pos + 1;
                    sum = 0;
                    foreach (sample_ring[i])
                        sum += sample_ring[i];
                    mean_now = MA_W'(sum / SAMPLE_COUNT_DEF);
                end
            end
            default:
            begin
                // unused code: state untouched
            end
        endcase
        r.limit = limit_now;
        r.mean = mean_now;
        expected_readings.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_MAX)
            $display("  mismatch at result %0d: %s got %0d, expected %0d",
                     results_seen, what, got, want);
    endtask

    // Send one request transaction; hold valid high after acceptance
    task automatic send_item(input logic [CMD_W-1:0] cmd, input int temp,
                             input logic [SEC_W-1:0] now, input logic [MA_W-1:0] sample_ma,
                             input logic active);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.command <= cmd;
        req.temperature <= 8'(temp);
        req.now_seconds <= now;
        req.current_sample <= sample_ma;
        req.time_table_active <= active;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        advance_monitor(cmd, 8'(temp), now, sample_ma, active);
        items_sent++;
        @(negedge clk);
    endtask

    // Write one register; the caller lowers valid after the last write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (cfg.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_MONITOR_ENABLE: mon_enable = value[0];
            CFG_IC_LIMIT:       ic_cfg = value[MA_W-1:0];
            CFG_TEMP_BAND_0, CFG_TEMP_BAND_1, CFG_TEMP_BAND_2:
                band_cfg[idx - CFG_TEMP_BAND_0] = value[BAND_BITS-1:0];
            default:
            begin
                row_cfg[2 * (idx - CFG_TIME_ROWS_01)] = value[ROW_BITS-1:0];
                row_cfg[2 * (idx - CFG_TIME_ROWS_01) + 1] = value[2*ROW_BITS-1:ROW_BITS];
            end
        endcase
        writes_done++;
        @(negedge clk);
    endtask

    // Load every register from the staged values; unused data bits get noise
    task automatic load_settings(input logic enable, input logic [MA_W-1:0] ic);
        write_register(CFG_MONITOR_ENABLE, {55'({$urandom, $urandom}), enable});
        write_register(CFG_IC_LIMIT, {44'({$urandom, $urandom}), ic});
        write_register(CFG_TEMP_BAND_0, {20'($urandom), band_words[0]});
        write_register(CFG_TEMP_BAND_1, {20'($urandom), band_words[1]});
        write_register(CFG_TEMP_BAND_2, {20'($urandom), band_words[2]});
        write_register(CFG_TIME_ROWS_01, {row_words[1], row_words[0]});
        write_register(CFG_TIME_ROWS_23, {row_words[3], row_words[2]});
        write_register(CFG_TIME_ROWS_45, {row_words[5], row_words[4]});
        cfg.valid <= 1'b0;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_results();
        req.valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    // Reset registers: limit stays at default, mean follows the samples
    task automatic test_power_on_defaults();
        send_item(CMD_TICK, -128, 32'd0, 12'd4095, 1'b1);
        send_item(CMD_UNUSED, 127, 32'hFFFF_FFFF, 12'd0, 1'b0);
        send_item(CMD_TICK, 0, 32'd7, 12'd0, 1'b1);
    endtask

    // Stop presets the ring, ticks while stopped keep it, start resumes
    task automatic test_sample_presets();
        send_item(CMD_STOP, 25, 32'd100, 12'd4095, 1'b1);
        send_item(CMD_TICK, 25, 32'd101, 12'd4095, 1'b1);
        send_item(CMD_START, 25, 32'd102, 12'd0, 1'b1);
        send_item(CMD_TICK, 25, 32'd103, 12'd4095, 1'b1);
    endtask

    // Rise into bands freely, hold on the way down within the back margin
    task automatic test_band_hysteresis();
        drain_results();
        band_words[0] = pack_band(-128, 0, 5, 1000);
        band_words[1] = pack_band(0, 40, 5, 800);
        band_words[2] = pack_band(40, 127, 255, 600);
        foreach (row_words[i])
            row_words[i] = '0;
        load_settings(1'b1, 12'd0);
        send_item(CMD_START, 20, 32'd500, 12'd1000, 1'b1);
        send_item(CMD_TICK, 20, 32'd501, 12'd1200, 1'b1);
        send_item(CMD_TICK, 127, 32'd502, 12'd1300, 1'b1);
        send_item(CMD_TICK, 38, 32'd503, 12'd900, 1'b1);
        send_item(CMD_TICK, 30, 32'd504, 12'd700, 1'b1);
        send_item(CMD_TICK, -128, 32'd505, 12'd600, 1'b1);
        send_item(CMD_TICK, 0, 32'd506, 12'd500, 1'b1);
    endtask

    // Walk elapsed seconds through rows 0 to 4, the hold window and a wrap
    task automatic test_time_rows();
        drain_results();
        band_words[0] = pack_band(-128, 127, 0, 0);
        band_words[1] = '0;
        band_words[2] = '0;
        row_words[0] = pack_row(16'hFFFF, 4095);
        row_words[1] = pack_row(1000, 700);
        row_words[2] = pack_row(100, 0);
        row_words[3] = pack_row(20, 900);
        row_words[4] = pack_row(0, 1);
        row_words[5] = '0;
        load_settings(1'b1, 12'd4095);
        send_item(CMD_START, 10, 32'd0, 12'd50, 1'b1);
        send_item(CMD_TICK, 10, 32'd5, 12'd60, 1'b1);
        send_item(CMD_TICK, 10, 32'd30, 12'd70, 1'b1);
        send_item(CMD_TICK, 10, 32'd55, 12'd80, 1'b1);
        send_item(CMD_TICK, 10, 32'd300, 12'd90, 1'b1);
        send_item(CMD_TICK, 10, 32'd2030, 12'd100, 1'b1);
        send_item(CMD_TICK, 10, 32'd65565, 12'd110, 1'b1);
        send_item(CMD_TICK, 10, 32'd65566, 12'd120, 1'b0);
        send_item(CMD_TICK, 10, 32'd3, 12'd130, 1'b1);
    endtask

    // Smallest IC limit wins; with monitoring off the limit is held
    task automatic test_ic_limit();
        drain_results();
        load_settings(1'b1, 12'd1);
        send_item(CMD_TICK, -5, 32'd4000, 12'd2048, 1'b1);
        drain_results();
        load_settings(1'b0, 12'd4095);
        send_item(CMD_TICK, -5, 32'd4001, 12'd1024, 1'b1);
    endtask

    // Random settings, then mostly well-formed tick runs with some noise
    task automatic run_random_phase(input int count, input bit calm);
        int              cur_temp, pick, bound, top;
        logic [SEC_W-1:0] clock_now;
        logic [MA_W-1:0] ic_value, level;
        logic            active;
        drain_results();
        idling_on = !calm && ($urandom_range(0, 3) != 0);
        // Contiguous bands, now and then a raw word
        bound = int'($urandom_range(0, 60)) - 70;
        for (int k = 0; k < BAND_REGS; k++)
        begin
            top = bound + int'($urandom_range(5, 45));
            band_words[k] = pack_band(bound, top, $urandom_range(0, 12),
                                      ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4095));
            if ($urandom_range(0, 9) == 0)
                band_words[k] = BAND_BITS'({$urandom, $urandom});
            bound = top;
        end
        // Rows with falling thresholds, now and then a raw word
        top = $urandom_range(200, 4000);
        for (int k = 0; k < ROW_REGS; k++)
        begin
            row_words[k] = pack_row(top,
                                    ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4095));
            if ($urandom_range(0, 9) == 0)
                row_words[k] = ROW_BITS'($urandom);
            top = top - int'($urandom_range(0, top));
        end
        case ($urandom_range(0, 5))
            0:       ic_value = 12'd0;
            1:       ic_value = 12'd1;
            2:       ic_value = 12'd4095;
            default: ic_value = 12'($urandom);
        endcase
        load_settings($urandom_range(0, 5) != 0, ic_value);

        case ($urandom_range(0, 5))
            0:       clock_now = $urandom_range(0, 9);
            1:       clock_now = 32'hFFFF_FF00 + $urandom_range(0, 200);
            default: clock_now = $urandom_range(10, 1000000);
        endcase
        cur_temp = int'($urandom_range(0, 100)) - 30;
        if ($urandom_range(0, 4) != 0)
            send_item(CMD_START, cur_temp, clock_now, 12'($urandom), 1'b1);

        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            // advance the wall clock and drift the temperature
            clock_now += ($urandom_range(0, 15) == 0) ? $urandom_range(0, 5000)
                                                      : $urandom_range(0, 40);
            cur_temp += int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 19) == 0)
                cur_temp = int'($urandom_range(0, 255)) - 128;
            if (cur_temp > 127)
                cur_temp = 127;
            if (cur_temp < -128)
                cur_temp = -128;
            if ($urandom_range(0, 7) == 0)
                level = ($urandom_range(0, 1) != 0) ? 12'd4095 : 12'd0;
            else
                level = 12'($urandom);
            active = ($urandom_range(0, 9) != 0);
            if (pick < 78)
                send_item(CMD_TICK, cur_temp, clock_now, level, active);
            else if (pick < 84)
                send_item(CMD_START, cur_temp, clock_now, level, active);
            else if (pick < 88)
                send_item(CMD_STOP, cur_temp, clock_now, level, active);
            else if (pick < 96)
                send_item(CMD_TICK, int'($urandom_range(0, 255)) - 128, $urandom,
                          12'($urandom), 1'($urandom));
            else
                send_item(CMD_UNUSED, int'($urandom_range(0, 255)) - 128, $urandom,
                          12'($urandom), 1'($urandom));
        end
    endtask

    // Result receiver: random stall bursts while idling is on
    always @(negedge clk)
    begin
        if (!idling_on)
            rsp.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            rsp.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            rsp.ready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end
        else
            rsp.ready <= 1'b1;
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("result with nothing pending, limit", rsp.current_limit, -1);
            else
            begin
                want = expected_readings.pop_front();
                if (rsp.current_limit !== want.limit)
                    report_mismatch("current_limit", rsp.current_limit, want.limit);
                if (rsp.average_current !== want.mean)
                    report_mismatch("average_current", rsp.average_current, want.mean);
            end
            results_seen++;
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (req.valid === 1'b1 && req.ready === 1'b1)
            || (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            || (cfg.valid === 1'b1 && cfg.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_MAX);
            $display("rx_current_limit_monitor_core verification failed");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.command = CMD_TICK;
        req.temperature = '0;
        req.now_seconds = '0;
        req.current_sample = '0;
        req.time_table_active = 1'b0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_MONITOR_ENABLE;
        cfg.data = '0;
        idling_on = 1'b1;

        // Predictor reset state
        mon_enable = 1'b0;
        ic_cfg = '0;
        foreach (band_cfg[i])
            band_cfg[i] = '0;
        foreach (row_cfg[i])
            row_cfg[i] = '0;
        origin_sec = '0;
        last_band = '0;
        first_tick = 1'b0;
        stopped = 1'b0;
        limit_now = DEFAULT_LIMIT;
        foreach (sample_ring[i])
            sample_ring[i] = '0;
        ring_pos = 0;
        mean_now = '0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_power_on_defaults();
        test_sample_presets();
        test_band_hysteresis();
        test_time_rows();
        test_ic_limit();
        for (int p = 0; p < 8; p++)
            run_random_phase(105, p == 7);
        drain_results();

        $display("Sent %0d requests and %0d register writes; checked %0d results.",
                 items_sent, writes_done, results_seen);
        $display("Covered band hysteresis, time rows, IC limit, stop presets and stalls.");
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("rx_current_limit_monitor_core verification clean");
        else
            $display("rx_current_limit_monitor_core verification failed");
        $finish;
    end

endmodule
